// ===== src/ipe_pkg.sv =====
// ipe_pkg: shared types, constants and helpers for the IPD payload extractor.
// Used by ipe_parser, ipe_out_reg and ipd_frame_payload_extractor_top.
// No dependencies.
package ipe_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_MATCH   = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  localparam int unsigned PFX_LEN = 5;
  localparam int unsigned POS_W   = 3;
  localparam int unsigned NUM_W   = 16;

  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'

  // Result word handed from the parser to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } result_t;

  // Parser status seen by the top level
  typedef struct packed {
    phase_t phase;
    logic   remaining_zero;
  } status_t;

  // Expected character of "+IPD," at a given match position
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_PLUS;
      3'd1:    ch = 8'h49;  // 'I'
      3'd2:    ch = 8'h50;  // 'P'
      3'd3:    ch = 8'h44;  // 'D'
      3'd4:    ch = CH_COMMA;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/ipe_parser.sv =====
// ipe_parser: "+IPD,<n>[,<n>...]:" header parser state and payload counter.
// Evaluates one registered word per step; result is combinational.
// Depends on ipe_pkg.
module ipe_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,      // consume the current word
  input  logic [7:0]        rx_byte,
  input  logic              resync,
  output ipe_pkg::result_t  res,
  output ipe_pkg::status_t  status
);

  ipe_pkg::phase_t                    phase, phase_next;
  logic [ipe_pkg::POS_W-1:0]          pos, pos_next;
  logic [ipe_pkg::NUM_W-1:0]          acc, acc_next;
  logic [ipe_pkg::NUM_W-1:0]          remaining, remaining_next;
  logic                               digit_seen, digit_seen_next;

  logic                               is_digit;
  logic [7:0]                         digit_val;
  logic [ipe_pkg::NUM_W-1:0]          acc_times10;
  logic [ipe_pkg::NUM_W-1:0]          rem_dec;
  logic                               prefix_hit;

  // Datapath helpers
  assign is_digit    = (rx_byte >= ipe_pkg::CH_ZERO) && (rx_byte <= ipe_pkg::CH_NINE);
  assign digit_val   = rx_byte - ipe_pkg::CH_ZERO;
  assign acc_times10 = {acc[ipe_pkg::NUM_W-4:0], 3'b000} + {acc[ipe_pkg::NUM_W-2:0], 1'b0};
  assign rem_dec     = remaining - ipe_pkg::NUM_W'(1);
  assign prefix_hit  = (pos < ipe_pkg::POS_W'(ipe_pkg::PFX_LEN))
                       && (rx_byte == ipe_pkg::prefix_char(pos));

  // Next-state logic
  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    acc_next        = acc;
    remaining_next  = remaining;
    digit_seen_next = digit_seen;
    if (resync) begin
      phase_next      = ipe_pkg::PH_HUNT;
      pos_next        = '0;
      acc_next        = '0;
      remaining_next  = '0;
      digit_seen_next = 1'b0;
    end else begin
      unique case (phase)
        ipe_pkg::PH_HUNT: begin
          if (rx_byte == ipe_pkg::CH_PLUS) begin
            pos_next   = ipe_pkg::POS_W'(1);
            phase_next = ipe_pkg::PH_MATCH;
          end
        end
        ipe_pkg::PH_MATCH: begin
          if (prefix_hit) begin
            pos_next = pos + ipe_pkg::POS_W'(1);
            if ((pos + ipe_pkg::POS_W'(1)) >= ipe_pkg::POS_W'(ipe_pkg::PFX_LEN)) begin
              phase_next      = ipe_pkg::PH_HEADER;
              acc_next        = '0;
              remaining_next  = '0;
              digit_seen_next = 1'b0;
            end
          end else if (rx_byte == ipe_pkg::CH_PLUS) begin
            pos_next = ipe_pkg::POS_W'(1);
          end else begin
            phase_next      = ipe_pkg::PH_HUNT;
            pos_next        = '0;
            acc_next        = '0;
            remaining_next  = '0;
            digit_seen_next = 1'b0;
          end
        end
        ipe_pkg::PH_HEADER: begin
          priority if (is_digit) begin
            acc_next        = acc_times10 + {8'h00, digit_val};
            digit_seen_next = 1'b1;
          end else if (rx_byte == ipe_pkg::CH_COMMA && digit_seen) begin
            acc_next        = '0;
            digit_seen_next = 1'b0;
          end else if (rx_byte == ipe_pkg::CH_COLON && digit_seen && acc != '0) begin
            remaining_next = acc;
            phase_next     = ipe_pkg::PH_PAYLOAD;
          end else begin
            // empty number, zero length or stray character: drop header
            phase_next      = ipe_pkg::PH_HUNT;
            pos_next        = '0;
            acc_next        = '0;
            remaining_next  = '0;
            digit_seen_next = 1'b0;
          end
        end
        ipe_pkg::PH_PAYLOAD: begin
          remaining_next = rem_dec;
          if (rem_dec == '0) begin
            phase_next      = ipe_pkg::PH_HUNT;
            pos_next        = '0;
            acc_next        = '0;
            digit_seen_next = 1'b0;
          end
        end
        default: phase_next = ipe_pkg::PH_HUNT;
      endcase
    end
  end

  // Output logic: payload bytes only
  always_comb begin
    res.valid = !resync && (phase == ipe_pkg::PH_PAYLOAD);
    res.data  = rx_byte;
    res.last  = (rem_dec == '0);
  end

  assign status.phase          = phase;
  assign status.remaining_zero = (remaining == '0);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ipe_pkg::PH_HUNT;
      pos        <= '0;
      acc        <= '0;
      remaining  <= '0;
      digit_seen <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      pos        <= pos_next;
      acc        <= acc_next;
      remaining  <= remaining_next;
      digit_seen <= digit_seen_next;
    end
  end

endmodule

// ===== src/ipe_out_reg.sv =====
// ipe_out_reg: result register driving the master-side stream channel.
// Depends on ipe_pkg.
module ipe_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ipe_pkg::result_t res,
  output logic             free,      // can take a word this cycle
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] payload_byte
  output logic             m_tlast    // last_in_packet
);

  assign free = !m_tvalid || m_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= res.data;
      m_tlast <= res.last;
    end
  end

endmodule

// ===== src/ipd_frame_payload_extractor_top.sv =====
// ipd_frame_payload_extractor_top: IPD frame payload extractor, top level.
// Depends on ipe_pkg, ipe_parser, ipe_out_reg.
//
// Usage:
//   Slave channel (s_*) takes one byte of the module's AT text link per
//   word, with s_tuser as a resync flag that drops back to prefix hunting
//   and discards the byte. The parser hunts for "+IPD,", reads the
//   comma-separated decimal header (16-bit wrap) and uses the last number
//   before ':' as payload length. Master channel (m_*) carries each payload
//   byte, with m_tlast on the final byte of the frame. Prefix, header and
//   resync words produce nothing on the master side.
//   Path: a payload word passes through the input register, then the parser
//   into the output register, which drives m_tvalid.
//   Throughput: one word per cycle unless a payload word stalls on a full
//   output register, set by the single parser step between the registers.
//   Reset: rst (synchronous) empties both registers and returns the parser
//   to prefix hunting.
//   Stall: when m_tready is low with a result pending, a payload word waits
//   in the input register and s_tready drops; non-payload words keep
//   flowing while the output register is full.
module ipd_frame_payload_extractor_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // resync
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic       m_tlast    // last_in_packet
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_resync;
  logic             advance;
  logic             out_free;
  ipe_pkg::result_t res;
  ipe_pkg::status_t status;

  // Input word advances unless it carries a result and the output is full
  assign advance  = in_valid && (!res.valid || out_free);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte   <= s_tdata;
      in_resync <= s_tuser;
    end
  end

  ipe_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (in_byte),
    .resync  (in_resync),
    .res     (res),
    .status  (status)
  );

  ipe_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res.valid),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A stalled input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("input word lost while stalled");

  // Payload phase always has bytes left to count
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    status.phase == ipe_pkg::PH_PAYLOAD |-> !status.remaining_zero)
    else $error("payload phase with zero bytes remaining");

  // Final payload byte returns the parser to hunting
  a_last_hunt: assert property (@(posedge clk) disable iff (rst)
    advance && res.valid && res.last |=> status.phase == ipe_pkg::PH_HUNT)
    else $error("parser not hunting after last payload byte");

  // Resync word returns the parser to hunting
  a_resync_hunt: assert property (@(posedge clk) disable iff (rst)
    advance && in_resync |=> status.phase == ipe_pkg::PH_HUNT)
    else $error("parser not hunting after resync");

endmodule
